// ===== hdl/smsf_pkg.sv =====
// ---------------------------------------------------------------------------
// smsf_pkg
// Types, codes and reset values shared by the modem session sequencer.
// ---------------------------------------------------------------------------
package smsf_pkg;

    localparam int PACKETS_PER_SNAPSHOT = 8;

    localparam int LIMIT_W = 20;
    localparam int CODE_W  = 8;
    localparam int TICK_W  = 32;

    // radio states
    localparam logic [2:0] ST_DISABLED   = 3'd0;
    localparam logic [2:0] ST_CONFIG     = 3'd1;
    localparam logic [2:0] ST_WAIT       = 3'd2;
    localparam logic [2:0] ST_TRANSCEIVE = 3'd3;
    localparam logic [2:0] ST_READ       = 3'd4;
    localparam logic [2:0] ST_WRITE      = 3'd5;

    // sub-task commands
    localparam logic [2:0] CMD_NONE       = 3'd0;
    localparam logic [2:0] CMD_CONFIG     = 3'd1;
    localparam logic [2:0] CMD_WRITE      = 3'd2;
    localparam logic [2:0] CMD_TRANSCEIVE = 3'd3;
    localparam logic [2:0] CMD_READ       = 3'd4;

    // register indexes
    localparam logic [2:0] REG_WAIT_LIMIT       = 3'd0;
    localparam logic [2:0] REG_TRANSCEIVE_LIMIT = 3'd1;
    localparam logic [2:0] REG_CONFIG_LIMIT     = 3'd2;
    localparam logic [2:0] REG_WRITE_LIMIT      = 3'd3;
    localparam logic [2:0] REG_READ_LIMIT       = 3'd4;
    localparam logic [2:0] REG_OK_CODE          = 3'd5;
    localparam logic [2:0] REG_UNAVAILABLE_CODE = 3'd6;
    localparam logic [2:0] REG_TIMEOUT_CODE     = 3'd7;

    localparam logic [LIMIT_W-1:0] WAIT_LIMIT_RST       = 20'd1;
    localparam logic [LIMIT_W-1:0] TRANSCEIVE_LIMIT_RST = 20'd500;
    localparam logic [LIMIT_W-1:0] CONFIG_LIMIT_RST     = 20'd300;
    localparam logic [LIMIT_W-1:0] WRITE_LIMIT_RST      = 20'd300;
    localparam logic [LIMIT_W-1:0] READ_LIMIT_RST       = 20'd300;
    localparam logic [CODE_W-1:0]  OK_CODE_RST          = 8'h00;
    localparam logic [CODE_W-1:0]  UNAVAILABLE_CODE_RST = 8'h01;
    localparam logic [CODE_W-1:0]  TIMEOUT_CODE_RST     = 8'hFF;
    localparam logic [LIMIT_W-1:0] TRANSCEIVE_THIRD_RST = 20'(500 / 3);

    // floor(x/3) = (x * THIRD_MUL) >> THIRD_SHIFT for any 20-bit x
    localparam logic [LIMIT_W-1:0] THIRD_MUL   = 20'd699051;
    localparam int                 THIRD_SHIFT = 21;

    localparam logic [7:0] MO_NO_LINK_MAX = 8'd4;
    localparam logic [7:0] MT_RETRIEVED   = 8'd1;

    typedef struct packed {
        logic [LIMIT_W-1:0]       wait_limit;
        logic [LIMIT_W-1:0]       transceive_limit;
        logic [LIMIT_W-1:0]       transceive_third;
        logic [LIMIT_W-1:0]       config_limit;
        logic [LIMIT_W-1:0]       write_limit;
        logic [LIMIT_W-1:0]       read_limit;
        logic signed [CODE_W-1:0] ok_code;
        logic signed [CODE_W-1:0] unavailable_code;
        logic signed [CODE_W-1:0] timeout_code;
    } cfg_t;

    typedef struct packed {
        logic                     override_valid;
        logic [2:0]               override_state;
        logic signed [CODE_W-1:0] sub_result;
        logic                     seq_zero_before;
        logic                     seq_zero_after;
        logic [7:0]               mo_status;
        logic [7:0]               mt_status;
        logic [8:0]               mt_length;
        logic                     power_cycling;
    } tick_t;

    typedef struct packed {
        logic [2:0]               state_now;
        logic [2:0]               sub_command;
        logic                     restart_sub;
        logic signed [CODE_W-1:0] error_code;
        logic                     take_snapshot;
        logic                     packet_valid;
        logic [2:0]               packet_number;
        logic [8:0]               received_length;
        logic [TICK_W-1:0]        last_contact_tick;
        logic                     recovery_pending;
    } result_t;

endpackage

// ===== hdl/smsf_ifs.sv =====
// ---------------------------------------------------------------------------
// smsf_ifs
// Valid/ready channels for tick beats and result beats.
// ---------------------------------------------------------------------------
interface smsf_tick_if;
    logic           valid;
    logic           ready;
    smsf_pkg::tick_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface smsf_result_if;
    logic              valid;
    logic              ready;
    smsf_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/smsf_cfg.sv =====
// ---------------------------------------------------------------------------
// smsf_cfg
// Configuration registers; also keeps a third of the transceive budget.
// ---------------------------------------------------------------------------
module smsf_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_index,
    input  logic [smsf_pkg::LIMIT_W-1:0]    cfg_data,
    output smsf_pkg::cfg_t                  cfg
);

    smsf_pkg::cfg_t                      cfg_reg;
    smsf_pkg::cfg_t                      cfg_next;
    logic [2*smsf_pkg::LIMIT_W-1:0]      third_prod;

    assign third_prod = cfg_data * smsf_pkg::THIRD_MUL;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                smsf_pkg::REG_WAIT_LIMIT:
                    cfg_next.wait_limit = cfg_data;
                smsf_pkg::REG_TRANSCEIVE_LIMIT:
                begin
                    cfg_next.transceive_limit = cfg_data;
                    cfg_next.transceive_third =
                        smsf_pkg::LIMIT_W'(third_prod >> smsf_pkg::THIRD_SHIFT);
                end
                smsf_pkg::REG_CONFIG_LIMIT:
                    cfg_next.config_limit = cfg_data;
                smsf_pkg::REG_WRITE_LIMIT:
                    cfg_next.write_limit = cfg_data;
                smsf_pkg::REG_READ_LIMIT:
                    cfg_next.read_limit = cfg_data;
                smsf_pkg::REG_OK_CODE:
                    cfg_next.ok_code = cfg_data[smsf_pkg::CODE_W-1:0];
                smsf_pkg::REG_UNAVAILABLE_CODE:
                    cfg_next.unavailable_code = cfg_data[smsf_pkg::CODE_W-1:0];
                smsf_pkg::REG_TIMEOUT_CODE:
                    cfg_next.timeout_code = cfg_data[smsf_pkg::CODE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wait_limit       <= smsf_pkg::WAIT_LIMIT_RST;
            cfg_reg.transceive_limit <= smsf_pkg::TRANSCEIVE_LIMIT_RST;
            cfg_reg.transceive_third <= smsf_pkg::TRANSCEIVE_THIRD_RST;
            cfg_reg.config_limit     <= smsf_pkg::CONFIG_LIMIT_RST;
            cfg_reg.write_limit      <= smsf_pkg::WRITE_LIMIT_RST;
            cfg_reg.read_limit       <= smsf_pkg::READ_LIMIT_RST;
            cfg_reg.ok_code          <= smsf_pkg::OK_CODE_RST;
            cfg_reg.unavailable_code <= smsf_pkg::UNAVAILABLE_CODE_RST;
            cfg_reg.timeout_code     <= smsf_pkg::TIMEOUT_CODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/smsf_step.sv =====
// ---------------------------------------------------------------------------
// smsf_step
// Session state and the per-tick transition logic.
// ---------------------------------------------------------------------------
module smsf_step #(
    parameter int PACKETS_PER_SNAPSHOT = smsf_pkg::PACKETS_PER_SNAPSHOT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  smsf_pkg::cfg_t    cfg,
    input  smsf_pkg::tick_t   item,
    output smsf_pkg::result_t res
);

    localparam int PIDX_W = (PACKETS_PER_SNAPSHOT > 1) ? $clog2(PACKETS_PER_SNAPSHOT) : 1;
    localparam logic [PIDX_W:0] PIDX_LAST = (PIDX_W + 1)'(PACKETS_PER_SNAPSHOT - 1);
    localparam int TW = smsf_pkg::TICK_W;
    localparam int LW = smsf_pkg::LIMIT_W;
    localparam int CW = smsf_pkg::CODE_W;

    logic [2:0]        mode_reg,    mode_next;
    logic [TW-1:0]     tick_reg;
    logic [TW-1:0]     entry_reg,   entry_next;
    logic [PIDX_W-1:0] pidx_reg,    pidx_next;
    logic              rec_reg,     rec_next;
    logic [CW-1:0]     err_reg,     err_next;
    logic [8:0]        len_reg,     len_next;
    logic [TW-1:0]     contact_reg, contact_next;

    logic [2:0]        mode;
    logic [TW-1:0]     elapsed;
    logic              finished;
    logic              real_err;
    logic              restart;
    logic [2:0]        cmd;
    logic              snap;
    logic              pkt_valid;
    logic [PIDX_W-1:0] pkt_idx;
    logic [PIDX_W+2:0] pkt_ext;
    logic [PIDX_W-1:0] pidx_inc;
    logic [LW-1:0]     left;
    logic              retry_over;
    logic              rec_cur;
    logic              tmo_cfg, tmo_wait, tmo_write, tmo_xcv, tmo_read;

    assign mode     = item.override_valid ? item.override_state : mode_reg;
    assign elapsed  = tick_reg - entry_reg;
    assign finished = item.seq_zero_after && (elapsed > TW'(1));
    assign real_err = (item.sub_result != cfg.ok_code)
                   && (item.sub_result != cfg.unavailable_code);

    assign tmo_cfg   = elapsed > TW'(cfg.config_limit);
    assign tmo_wait  = elapsed > TW'(cfg.wait_limit);
    assign tmo_write = elapsed > TW'(cfg.write_limit);
    assign tmo_xcv   = elapsed > TW'(cfg.transceive_limit);
    assign tmo_read  = elapsed > TW'(cfg.read_limit);

    // only used while elapsed is within the transceive budget
    assign left       = cfg.transceive_limit - elapsed[LW-1:0];
    assign retry_over = {1'b0, left} <= ({1'b0, cfg.transceive_third} + (LW + 1)'(1));

    assign pidx_inc = ({1'b0, pidx_reg} == PIDX_LAST) ? '0 : pidx_reg + PIDX_W'(1);

    always_comb
    begin
        mode_next    = mode;
        entry_next   = entry_reg;
        pidx_next    = pidx_reg;
        rec_next     = rec_reg;
        err_next     = err_reg;
        len_next     = len_reg;
        contact_next = contact_reg;
        restart      = 1'b0;
        cmd          = smsf_pkg::CMD_NONE;
        snap         = 1'b0;
        pkt_valid    = 1'b0;
        pkt_idx      = '0;
        rec_cur      = rec_reg;

        unique case (mode)
            smsf_pkg::ST_DISABLED:
            begin
                restart    = 1'b1;
                entry_next = tick_reg;
            end
            smsf_pkg::ST_CONFIG:
            begin
                if (tmo_cfg)
                begin
                    err_next = cfg.timeout_code;
                    rec_next = 1'b1;
                    mode_next = smsf_pkg::ST_WAIT;
                    restart = 1'b1;
                    entry_next = tick_reg;
                end
                else
                begin
                    cmd = smsf_pkg::CMD_CONFIG;
                    if (real_err)
                    begin
                        err_next = item.sub_result;
                        rec_next = 1'b1;
                        mode_next = smsf_pkg::ST_WAIT;
                        restart = 1'b1;
                        entry_next = tick_reg;
                    end
                    else if (finished)
                    begin
                        pidx_next = '0;
                        mode_next = smsf_pkg::ST_WRITE;
                        restart = 1'b1;
                        entry_next = tick_reg;
                    end
                end
            end
            smsf_pkg::ST_WRITE:
            begin
                if (tmo_write)
                begin
                    err_next = cfg.timeout_code;
                    rec_next = 1'b1;
                    mode_next = smsf_pkg::ST_WAIT;
                    restart = 1'b1;
                    entry_next = tick_reg;
                end
                else
                begin
                    if (item.seq_zero_before && (elapsed <= TW'(1)))
                    begin
                        snap      = (pidx_reg == '0);
                        pkt_valid = 1'b1;
                        pkt_idx   = pidx_reg;
                        pidx_next = pidx_inc;
                    end
                    cmd = smsf_pkg::CMD_WRITE;
                    if (real_err)
                    begin
                        err_next = item.sub_result;
                        rec_next = 1'b1;
                        mode_next = smsf_pkg::ST_WAIT;
                        restart = 1'b1;
                        entry_next = tick_reg;
                    end
                    else if (finished)
                    begin
                        mode_next = smsf_pkg::ST_TRANSCEIVE;
                        restart = 1'b1;
                        entry_next = tick_reg;
                    end
                end
            end
            smsf_pkg::ST_TRANSCEIVE:
            begin
                if (tmo_xcv)
                begin
                    err_next = cfg.timeout_code;
                    rec_next = 1'b1;
                    mode_next = smsf_pkg::ST_WAIT;
                    restart = 1'b1;
                    entry_next = tick_reg;
                end
                else
                begin
                    cmd = smsf_pkg::CMD_TRANSCEIVE;
                    if (real_err)
                    begin
                        err_next = item.sub_result;
                        rec_next = 1'b1;
                        mode_next = smsf_pkg::ST_WAIT;
                        restart = 1'b1;
                        entry_next = tick_reg;
                    end
                    else if (finished)
                    begin
                        if (item.mo_status > smsf_pkg::MO_NO_LINK_MAX)
                        begin
                            if (retry_over)
                            begin
                                pidx_next = '0;
                                mode_next = smsf_pkg::ST_WRITE;
                                restart = 1'b1;
                                entry_next = tick_reg;
                            end
                        end
                        else
                        begin
                            contact_next = tick_reg;
                            mode_next = (item.mt_status == smsf_pkg::MT_RETRIEVED)
                                      ? smsf_pkg::ST_READ : smsf_pkg::ST_WRITE;
                            restart = 1'b1;
                            entry_next = tick_reg;
                        end
                    end
                end
            end
            smsf_pkg::ST_READ:
            begin
                if (tmo_read)
                begin
                    err_next = cfg.timeout_code;
                    rec_next = 1'b1;
                    mode_next = smsf_pkg::ST_WAIT;
                    restart = 1'b1;
                    entry_next = tick_reg;
                end
                else
                begin
                    cmd = smsf_pkg::CMD_READ;
                    if (real_err)
                    begin
                        err_next = item.sub_result;
                        rec_next = 1'b1;
                        mode_next = smsf_pkg::ST_WAIT;
                        restart = 1'b1;
                        entry_next = tick_reg;
                    end
                    else if (finished)
                    begin
                        len_next = item.mt_length;
                        mode_next = smsf_pkg::ST_WRITE;
                        restart = 1'b1;
                        entry_next = tick_reg;
                    end
                end
            end
            default:
            begin
                // wait, and the invalid codes which force recovery
                if (mode != smsf_pkg::ST_WAIT)
                begin
                    rec_cur = 1'b1;
                end
                rec_next = rec_cur;
                if (tmo_wait && !item.power_cycling)
                begin
                    restart = 1'b1;
                    entry_next = tick_reg;
                    if (rec_cur)
                    begin
                        rec_next = 1'b0;
                        mode_next = smsf_pkg::ST_CONFIG;
                    end
                    else
                    begin
                        pidx_next = '0;
                        mode_next = smsf_pkg::ST_WRITE;
                    end
                end
            end
        endcase
    end

    assign pkt_ext = {3'b000, pkt_idx};

    always_comb
    begin
        res.state_now         = mode_next;
        res.sub_command       = cmd;
        res.restart_sub       = restart;
        res.error_code        = err_next;
        res.take_snapshot     = snap;
        res.packet_valid      = pkt_valid;
        res.packet_number     = pkt_ext[2:0];
        res.received_length   = len_next;
        res.last_contact_tick = contact_next;
        res.recovery_pending  = rec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= smsf_pkg::ST_DISABLED;
            tick_reg    <= '0;
            entry_reg   <= '0;
            pidx_reg    <= '0;
            rec_reg     <= 1'b0;
            err_reg     <= '0;
            len_reg     <= '0;
            contact_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg    <= mode_next;
            tick_reg    <= tick_reg + TW'(1);
            entry_reg   <= entry_next;
            pidx_reg    <= pidx_next;
            rec_reg     <= rec_next;
            err_reg     <= err_next;
            len_reg     <= len_next;
            contact_reg <= contact_next;
        end
    end

endmodule

// ===== hdl/satellite_modem_session_fsm.sv =====
// ---------------------------------------------------------------------------
// satellite_modem_session_fsm
// Modem session sequencer: one control tick in, one result beat out.
// ---------------------------------------------------------------------------
// Usage:
//   tick   : valid/ready sink; each beat is one control tick carrying the
//            radio sub-task results for that tick.
//   result : valid/ready source; exactly one beat per tick beat, in order.
//   cfg_we/cfg_index/cfg_data : register writes, taken on any edge with
//            cfg_we high; write only while no tick is in flight.
// Path: a taken tick beat is registered in the input register, processed
//   once the result register is free, and its result beat is registered.
// Throughput: one tick per cycle while every result beat is taken; an
//   untaken result beat stalls the state update between the two registers.
// Reset: the session is disabled, tick counter, error, lengths and contact
//   tick clear and the configuration registers take their defaults.
// Stall: while result is not taken the result beat holds; one further tick
//   beat is held in the input register, after which tick.ready drops.
// ---------------------------------------------------------------------------
module satellite_modem_session_fsm #(
    parameter int PACKETS_PER_SNAPSHOT = smsf_pkg::PACKETS_PER_SNAPSHOT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    smsf_tick_if.sink                    tick,
    smsf_result_if.source                result,
    input  logic                         cfg_we,
    input  logic [2:0]                   cfg_index,
    input  logic [smsf_pkg::LIMIT_W-1:0] cfg_data
);

    smsf_pkg::cfg_t    cfg;
    smsf_pkg::tick_t   in_data_reg;
    logic              in_valid_reg;
    smsf_pkg::result_t out_data_reg;
    logic              out_valid_reg;
    smsf_pkg::result_t step_res;
    logic              fire;

    assign fire       = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || fire;

    smsf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    smsf_step #(
        .PACKETS_PER_SNAPSHOT (PACKETS_PER_SNAPSHOT)
    ) u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .cfg   (cfg),
        .item  (in_data_reg),
        .res   (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick.ready)
            begin
                in_valid_reg <= tick.valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
        begin
            in_data_reg <= tick.data;
        end
        if (fire)
        begin
            out_data_reg <= step_res;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

// ===== tb/tb_satellite_modem_session_fsm.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_satellite_modem_session_fsm
// Feeds control-tick beats to the modem session sequencer and checks each
// result beat, field by field, against a behavioural copy of the session.
// The run covers a directed walk through every state and several register
// settings, from all-zero budgets to the largest ones, under varied pacing.
// ---------------------------------------------------------------------------
module tb_satellite_modem_session_fsm;
    import smsf_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [LIMIT_W-1:0] cfg_data;

    smsf_tick_if   tick_ch ();
    smsf_result_if res_ch ();

    satellite_modem_session_fsm u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // session model registers
    logic [LIMIT_W-1:0] lim_wait, lim_xcv, lim_cfg, lim_write, lim_read;
    logic [CODE_W-1:0]  code_ok, code_busy, code_timeout;

    logic [2:0]  sess_mode;
    logic [31:0] sess_tick, sess_entry, sess_contact;
    int unsigned sess_pkt;
    logic        sess_recover, sess_restart;
    logic [7:0]  sess_err;
    logic [8:0]  sess_len;

    tick_t       pending_ticks[$];
    result_t     expected_results[$];
    int unsigned send_gap_pct, recv_stall_pct;
    int unsigned ticks_sent = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches = 0;
    int unsigned snapshots = 0;
    logic [7:0]  states_seen = '0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void enter_state(logic [2:0] st);
        sess_entry   = sess_tick;
        sess_restart = 1'b1;
        sess_mode    = st;
    endfunction

    function automatic void record_failure(logic [7:0] code);
        sess_err     = code;
        sess_recover = 1'b1;
        enter_state(ST_WAIT);
    endfunction

    function automatic void wait_step(logic [31:0] spent, logic power_cycling);
        if (spent > lim_wait && !power_cycling)
        begin
            if (sess_recover)
            begin
                sess_recover = 1'b0;
                enter_state(ST_CONFIG);
            end
            else
            begin
                sess_pkt = 0;
                enter_state(ST_WRITE);
            end
        end
    endfunction

    function automatic logic is_fault(logic [7:0] code);
        return code != code_ok && code != code_busy;
    endfunction

    // one control tick through the session; returns the expected result beat
    function automatic result_t step_session(tick_t t);
        result_t     r;
        logic [31:0] spent;
        logic [31:0] left;
        logic        done;
        r = '0;
        sess_restart = 1'b0;
        if (t.override_valid)
            sess_mode = t.override_state;
        spent = sess_tick - sess_entry;
        done  = t.seq_zero_after && spent > 1;
        case (sess_mode)
            ST_DISABLED:
                enter_state(ST_DISABLED);
            ST_CONFIG:
                if (spent > lim_cfg)
                    record_failure(code_timeout);
                else
                begin
                    r.sub_command = CMD_CONFIG;
                    if (is_fault(t.sub_result))
                        record_failure(t.sub_result);
                    else if (done)
                    begin
                        sess_pkt = 0;
                        enter_state(ST_WRITE);
                    end
                end
            ST_WAIT:
                wait_step(spent, t.power_cycling);
            ST_WRITE:
                if (spent > lim_write)
                    record_failure(code_timeout);
                else
                begin
                    if (t.seq_zero_before && spent <= 1)
                    begin
                        r.take_snapshot = (sess_pkt == 0);
                        r.packet_valid  = 1'b1;
                        r.packet_number = sess_pkt[2:0];
                        sess_pkt = (sess_pkt + 1) % PACKETS_PER_SNAPSHOT;
                    end
                    r.sub_command = CMD_WRITE;
                    if (is_fault(t.sub_result))
                        record_failure(t.sub_result);
                    else if (done)
                        enter_state(ST_TRANSCEIVE);
                end
            ST_TRANSCEIVE:
                if (spent > lim_xcv)
                    record_failure(code_timeout);
                else
                begin
                    r.sub_command = CMD_TRANSCEIVE;
                    if (is_fault(t.sub_result))
                        record_failure(t.sub_result);
                    else if (done)
                    begin
                        if (t.mo_status > MO_NO_LINK_MAX)
                        begin
                            // no link: give up once a third of the budget is left
                            left = 32'(lim_xcv) - spent;
                            if (left <= 32'(lim_xcv) / 3 + 1)
                            begin
                                sess_pkt = 0;
                                enter_state(ST_WRITE);
                            end
                        end
                        else
                        begin
                            sess_contact = sess_tick;
                            enter_state(t.mt_status == MT_RETRIEVED ? ST_READ : ST_WRITE);
                        end
                    end
                end
            ST_READ:
                if (spent > lim_read)
                    record_failure(code_timeout);
                else
                begin
                    r.sub_command = CMD_READ;
                    if (is_fault(t.sub_result))
                        record_failure(t.sub_result);
                    else if (done)
                    begin
                        sess_len = t.mt_length;
                        enter_state(ST_WRITE);
                    end
                end
            default:
            begin
                sess_recover = 1'b1;
                wait_step(spent, t.power_cycling);
            end
        endcase
        r.state_now         = sess_mode;
        r.restart_sub       = sess_restart;
        r.error_code        = sess_err;
        r.received_length   = sess_len;
        r.last_contact_tick = sess_contact;
        r.recovery_pending  = sess_recover;
        sess_tick = sess_tick + 1;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function automatic void check_result(result_t got);
        result_t want;
        if (expected_results.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
            return;
        end
        want = expected_results.pop_front();
        check_field("state_now", 32'(want.state_now), 32'(got.state_now));
        check_field("sub_command", 32'(want.sub_command), 32'(got.sub_command));
        check_field("restart_sub", 32'(want.restart_sub), 32'(got.restart_sub));
        check_field("error_code", {24'd0, want.error_code}, {24'd0, got.error_code});
        check_field("take_snapshot", 32'(want.take_snapshot), 32'(got.take_snapshot));
        check_field("packet_valid", 32'(want.packet_valid), 32'(got.packet_valid));
        check_field("packet_number", 32'(want.packet_number), 32'(got.packet_number));
        check_field("received_length", 32'(want.received_length),
                    32'(got.received_length));
        check_field("last_contact_tick", want.last_contact_tick, got.last_contact_tick);
        check_field("recovery_pending", 32'(want.recovery_pending),
                    32'(got.recovery_pending));
        results_checked++;
        states_seen[got.state_now] = 1'b1;
        if (got.take_snapshot === 1'b1)
            snapshots++;
    endfunction

    function automatic logic [7:0] random_code();
        return 8'(int'($urandom_range(100)) - 90);
    endfunction

    function automatic tick_t make_tick(logic ov, logic [2:0] st, logic [7:0] res,
                                        logic sb, logic sa, logic [7:0] mo,
                                        logic [7:0] mt, logic [8:0] len, logic pc);
        tick_t t;
        t.override_valid  = ov;
        t.override_state  = st;
        t.sub_result      = res;
        t.seq_zero_before = sb;
        t.seq_zero_after  = sa;
        t.mo_status       = mo;
        t.mt_status       = mt;
        t.mt_length       = len;
        t.power_cycling   = pc;
        return t;
    endfunction

    // mostly well-formed ticks: success or busy codes, with sequence ends often
    function automatic tick_t random_tick();
        tick_t       t;
        int unsigned roll;
        t.override_valid  = ($urandom_range(99) < 3);
        t.override_state  = 3'($urandom_range(7));
        roll = $urandom_range(99);
        if (roll < 45)
            t.sub_result = code_ok;
        else if (roll < 88)
            t.sub_result = code_busy;
        else
            t.sub_result = random_code();
        t.seq_zero_before = 1'($urandom_range(1));
        t.seq_zero_after  = ($urandom_range(99) < 40);
        t.mo_status       = $urandom_range(1) ? 8'($urandom_range(4)) : 8'($urandom_range(255));
        t.mt_status       = $urandom_range(1) ? MT_RETRIEVED : 8'($urandom_range(255));
        t.mt_length       = 9'($urandom_range(511));
        t.power_cycling   = ($urandom_range(99) < 12);
        return t;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [LIMIT_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_WAIT_LIMIT:       lim_wait     = value;
            REG_TRANSCEIVE_LIMIT: lim_xcv      = value;
            REG_CONFIG_LIMIT:     lim_cfg      = value;
            REG_WRITE_LIMIT:      lim_write    = value;
            REG_READ_LIMIT:       lim_read     = value;
            REG_OK_CODE:          code_ok      = value[7:0];
            REG_UNAVAILABLE_CODE: code_busy    = value[7:0];
            REG_TIMEOUT_CODE:     code_timeout = value[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [LIMIT_W-1:0] w, logic [LIMIT_W-1:0] x,
                                  logic [LIMIT_W-1:0] c, logic [LIMIT_W-1:0] wr,
                                  logic [LIMIT_W-1:0] rd, logic [7:0] ok,
                                  logic [7:0] busy, logic [7:0] tmo);
        write_reg(REG_WAIT_LIMIT, w);
        write_reg(REG_TRANSCEIVE_LIMIT, x);
        write_reg(REG_CONFIG_LIMIT, c);
        write_reg(REG_WRITE_LIMIT, wr);
        write_reg(REG_READ_LIMIT, rd);
        write_reg(REG_OK_CODE, {12'd0, ok});
        write_reg(REG_UNAVAILABLE_CODE, {12'd0, busy});
        write_reg(REG_TIMEOUT_CODE, {12'd0, tmo});
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // hold off until every beat sent has come back
    task automatic drain();
        while (pending_ticks.size() != 0 || tick_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(int unsigned count);
        repeat (count) pending_ticks.push_back(random_tick());
        drain();
    endtask

    // tick beat driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_ch.valid <= 1'b0;
        else
        begin
            if (tick_ch.valid && tick_ch.ready)
            begin
                expected_results.push_back(step_session(tick_ch.data));
                ticks_sent++;
            end
            if (!tick_ch.valid || tick_ch.ready)
            begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    tick_ch.data  <= pending_ticks.pop_front();
                    tick_ch.valid <= 1'b1;
                end
                else
                    tick_ch.valid <= 1'b0;
            end
        end
    end

    // result beat monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
                check_result(res_ch.data);
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        tick_ch.valid = 1'b0;
        tick_ch.data  = '0;
        res_ch.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_WAIT_LIMIT;
        cfg_data      = '0;
        rst_n         = 1'b0;

        lim_wait     = WAIT_LIMIT_RST;
        lim_xcv      = TRANSCEIVE_LIMIT_RST;
        lim_cfg      = CONFIG_LIMIT_RST;
        lim_write    = WRITE_LIMIT_RST;
        lim_read     = READ_LIMIT_RST;
        code_ok      = OK_CODE_RST;
        code_busy    = UNAVAILABLE_CODE_RST;
        code_timeout = TIMEOUT_CODE_RST;
        sess_mode    = ST_DISABLED;
        sess_tick    = '0;
        sess_entry   = '0;
        sess_contact = '0;
        sess_pkt     = 0;
        sess_recover = 1'b0;
        sess_restart = 1'b0;
        sess_err     = '0;
        sess_len     = '0;

        send_gap_pct   = 7;
        recv_stall_pct = 74;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed walk: short budgets so every exit is reached quickly
        apply_settings(20'd0, 20'd6, 20'd2, 20'd4, 20'd4,
                       OK_CODE_RST, UNAVAILABLE_CODE_RST, TIMEOUT_CODE_RST);
        pending_ticks.push_back(make_tick(0, ST_DISABLED, OK_CODE_RST, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(1, ST_CONFIG, UNAVAILABLE_CODE_RST, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, OK_CODE_RST, 0, 1, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, OK_CODE_RST, 1, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, OK_CODE_RST, 1, 1, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, OK_CODE_RST, 0, 1, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, UNAVAILABLE_CODE_RST,
                                          0, 0, 255, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, OK_CODE_RST, 0, 1, 5, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, OK_CODE_RST, 0, 1, 255, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, OK_CODE_RST, 1, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, OK_CODE_RST, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, OK_CODE_RST, 0, 1, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, OK_CODE_RST, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, OK_CODE_RST, 0, 1, 4, 1, 0, 0));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, OK_CODE_RST, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, OK_CODE_RST, 0, 1, 0, 0, 511, 0));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, -8'sd90, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, OK_CODE_RST, 0, 0, 0, 0, 0, 1));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, OK_CODE_RST, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, OK_CODE_RST, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, OK_CODE_RST, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(0, ST_DISABLED, OK_CODE_RST, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(1, 3'd7, OK_CODE_RST, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(1, 3'd6, OK_CODE_RST, 0, 0, 0, 0, 0, 1));
        pending_ticks.push_back(make_tick(1, ST_WAIT, OK_CODE_RST, 0, 0, 0, 0, 0, 0));
        pending_ticks.push_back(make_tick(1, ST_DISABLED, 8'sd10, 1, 1, 255, 255, 0, 1));
        drain();

        apply_settings(WAIT_LIMIT_RST, TRANSCEIVE_LIMIT_RST, CONFIG_LIMIT_RST,
                       WRITE_LIMIT_RST, READ_LIMIT_RST,
                       OK_CODE_RST, UNAVAILABLE_CODE_RST, TIMEOUT_CODE_RST);
        run_random(300);

        apply_settings(20'd0, 20'd9, 20'd2, 20'd3, 20'd2, -8'sd90, 8'sd10, 8'sd5);
        run_random(300);

        send_gap_pct   = 74;
        recv_stall_pct = 7;
        apply_settings('1, '1, '1, '1, '1, 8'sd10, -8'sd90, -8'sd90);
        run_random(300);

        apply_settings(20'($urandom_range(3)), 20'($urandom_range(20)),
                       20'($urandom_range(20)), 20'($urandom_range(20)),
                       20'($urandom_range(20)), random_code(), random_code(), random_code());
        run_random(350);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        apply_settings('0, '0, '0, '0, '0, 8'sd3, -8'sd3, 8'sd0);
        run_random(250);

        apply_settings(20'($urandom_range(3)), 20'($urandom_range(12)),
                       20'($urandom_range(12)), 20'($urandom_range(12)),
                       20'($urandom_range(12)), random_code(), random_code(), random_code());
        run_random(350);

        repeat (8) @(posedge clk);
        $display("Run covered %0d tick beats and %0d result beats over seven register settings,",
                 ticks_sent, results_checked);
        $display("state codes seen %b, %0d snapshots taken.", states_seen, snapshots);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/smsf_pkg.sv
hdl/smsf_ifs.sv
hdl/smsf_cfg.sv
hdl/smsf_step.sv
hdl/satellite_modem_session_fsm.sv
tb/tb_satellite_modem_session_fsm.sv
